### rtl/flp_pkg.sv
// Shared constants, register codes and types of the five-point Laplacian patch unit.
package flp_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int BUF_DEPTH  = MAX_WIDTH + 2;
	localparam int CNT_W      = $clog2(BUF_DEPTH + 1);

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 6;
	localparam int SIZE_W    = 7;
	localparam int MASK_W    = 4;
	localparam int TDATA_W   = 48;
	localparam int CFG_IDX_W = 2;

	localparam int CENTRE_SHIFT = 2;
	localparam int FRAC_W       = 16;
	localparam int SUM_W        = DATA_W + 4;
	localparam int PROD_W       = SUM_W + FRAC_W + 1;
	localparam int Q_W          = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_PATCH_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATCH_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR     = 2'd3;

	localparam logic [SIZE_W-1:0] RESET_SIZE    = 7'd8;
	localparam logic [DATA_W-1:0] RESET_INV     = 32'd65536;
	localparam logic [MASK_W-1:0] RESET_MASK    = 4'd0;
	localparam int                MASK_WEST     = 0;
	localparam int                MASK_EAST     = 1;
	localparam int                MASK_SOUTH    = 2;
	localparam int                MASK_NORTH    = 3;

	localparam logic [DATA_W-1:0] LAP_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] LAP_MIN = 32'h8000_0000;

	typedef struct packed {
		logic west;
		logic east;
		logic south;
		logic north;
	} ghost_sel_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] north;
		logic signed [DATA_W-1:0] south;
		logic signed [DATA_W-1:0] east;
		logic signed [DATA_W-1:0] west;
		logic signed [DATA_W-1:0] centre;
		ghost_sel_t               mirror;
	} operand_t;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
		logic             last;
	} meta_t;

endpackage

### rtl/five_point_laplacian_patch_unit.sv
// Top level of the five-point Laplacian patch unit: counters, line buffers, window cells.
// Throughput: one cell value per cycle while s_axis_tready is high; results leave in raster order.
// Pipeline: once the item directly north of a cell is taken, the cell's result passes through the
// operand register (accepting edge), then sum, split multiply, saturate/output register.
// Line buffers are two ping-pong RAMs of MAX_WIDTH+2 words, one read port each.
// Reset clears counters, pipeline valids and the registers to defaults; buffers keep contents.
module five_point_laplacian_patch_unit import flp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] cell_value
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TDATA_W-1:0]   m_axis_tdata,   // [31:0] laplacian, [37:32] column, [43:38] row
	output logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	logic [SIZE_W-1:0] patch_width_q, patch_height_q;
	logic [DATA_W-1:0] inv_spacing_q;
	logic [MASK_W-1:0] neighbor_mask_q;

	logic [CNT_W-1:0] w_eff, h_eff;
	logic [CNT_W-1:0] col_q, row_q, col_next, row_next, col_east;
	logic [CNT_W:0]   col_inc, row_inc;
	logic             row_wrap, patch_wrap;
	logic             bank_q, bank_next;
	logic             accept, is_cell;

	logic [DATA_W-1:0] rd0, rd1, south_rd, east_rd;
	logic [CNT_W-1:0]  rd_addr0, rd_addr1;
	logic              we0, we1;
	logic [DATA_W-1:0] ghost_q, west_q, centre_q;

	logic     ld1, v_s1, arith_ready;
	operand_t opnd_s1;
	meta_t    meta_s1, out_meta;
	logic [DATA_W-1:0] lap;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_width_q   <= RESET_SIZE;
			patch_height_q  <= RESET_SIZE;
			inv_spacing_q   <= RESET_INV;
			neighbor_mask_q <= RESET_MASK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATCH_WIDTH:  patch_width_q   <= cfg_data[SIZE_W-1:0];
				REG_PATCH_HEIGHT: patch_height_q  <= cfg_data[SIZE_W-1:0];
				REG_INV_SPACING:  inv_spacing_q   <= cfg_data;
				REG_NEIGHBOR:     neighbor_mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (patch_width_q == '0) ? CNT_W'(1)
		: (CNT_W'(patch_width_q) > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(patch_width_q);
	assign h_eff = (patch_height_q == '0) ? CNT_W'(1)
		: (CNT_W'(patch_height_q) > CNT_W'(MAX_HEIGHT)) ? CNT_W'(MAX_HEIGHT)
		: CNT_W'(patch_height_q);

	assign accept = s_axis_tvalid && s_axis_tready;

	assign col_inc    = {1'b0, col_q} + (CNT_W+1)'(1);
	assign row_inc    = {1'b0, row_q} + (CNT_W+1)'(1);
	assign row_wrap   = col_inc >= ({1'b0, w_eff} + (CNT_W+1)'(2));
	assign patch_wrap = row_inc >= ({1'b0, h_eff} + (CNT_W+1)'(2));

	always_comb begin
		col_next  = col_q;
		row_next  = row_q;
		bank_next = bank_q;
		if (accept) begin
			if (row_wrap) begin
				col_next  = '0;
				bank_next = ~bank_q;
				row_next  = patch_wrap ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_next = col_inc[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= 1'b0;
		end else begin
			col_q  <= col_next;
			row_q  <= row_next;
			bank_q <= bank_next;
		end
	end

	assign col_east = col_next + CNT_W'(1);
	assign rd_addr0 = bank_next ? col_east : col_next;
	assign rd_addr1 = bank_next ? col_next : col_east;
	assign we0      = accept && !bank_q && (col_q < CNT_W'(BUF_DEPTH));
	assign we1      = accept && bank_q && (col_q < CNT_W'(BUF_DEPTH));

	flp_ram #(.WIDTH(DATA_W), .DEPTH(BUF_DEPTH)) u_buf0 (
		.clk     (clk),
		.wr_en   (we0),
		.wr_addr (col_q),
		.wr_data (s_axis_tdata),
		.rd_addr (rd_addr0),
		.rd_data (rd0)
	);

	flp_ram #(.WIDTH(DATA_W), .DEPTH(BUF_DEPTH)) u_buf1 (
		.clk     (clk),
		.wr_en   (we1),
		.wr_addr (col_q),
		.wr_data (s_axis_tdata),
		.rd_addr (rd_addr1),
		.rd_data (rd1)
	);

	assign south_rd = bank_q ? rd1 : rd0;
	assign east_rd  = bank_q ? rd0 : rd1;

	flp_cell u_ghost (
		.clk (clk),
		.en  (accept && (col_q == '0)),
		.sel (1'b0),
		.d_a (s_axis_tdata),
		.d_b (centre_q),
		.q   (ghost_q)
	);

	flp_cell u_west (
		.clk (clk),
		.en  (accept),
		.sel (col_q == '0),
		.d_a (centre_q),
		.d_b (ghost_q),
		.q   (west_q)
	);

	flp_cell u_centre (
		.clk (clk),
		.en  (accept),
		.sel (1'b0),
		.d_a (east_rd),
		.d_b (west_q),
		.q   (centre_q)
	);

	assign is_cell = (row_q >= CNT_W'(2)) && (row_q <= h_eff + CNT_W'(1))
		&& (col_q >= CNT_W'(1)) && (col_q <= w_eff);

	assign ld1           = !v_s1 || arith_ready;
	assign s_axis_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld1) begin
			v_s1 <= accept && is_cell;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			opnd_s1.north        <= $signed(s_axis_tdata);
			opnd_s1.south        <= $signed(south_rd);
			opnd_s1.east         <= $signed(east_rd);
			opnd_s1.west         <= $signed(west_q);
			opnd_s1.centre       <= $signed(centre_q);
			opnd_s1.mirror.west  <= (col_q == CNT_W'(1)) && !neighbor_mask_q[MASK_WEST];
			opnd_s1.mirror.east  <= (col_q == w_eff) && !neighbor_mask_q[MASK_EAST];
			opnd_s1.mirror.south <= (row_q == CNT_W'(2)) && !neighbor_mask_q[MASK_SOUTH];
			opnd_s1.mirror.north <= (row_q == h_eff + CNT_W'(1)) && !neighbor_mask_q[MASK_NORTH];
			meta_s1.column       <= IDX_W'(col_q - CNT_W'(1));
			meta_s1.row          <= IDX_W'(row_q - CNT_W'(2));
			meta_s1.last         <= (row_q == h_eff + CNT_W'(1)) && (col_q == w_eff);
		end
	end

	flp_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (arith_ready),
		.opnd      (opnd_s1),
		.meta      (meta_s1),
		.inv       (inv_spacing_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.lap       (lap),
		.out_meta  (out_meta)
	);

	assign m_axis_tdata = {{(TDATA_W-DATA_W-2*IDX_W){1'b0}}, out_meta.row, out_meta.column, lap};
	assign m_axis_tlast = out_meta.last;

	assert property (@(posedge clk) disable iff (!arst_n) col_q < CNT_W'(BUF_DEPTH))
		else $error("column counter beyond line buffer");

	assert property (@(posedge clk) disable iff (!arst_n) row_q <= CNT_W'(MAX_HEIGHT + 1))
		else $error("row counter beyond patch");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_wrap) |=> (bank_q != $past(bank_q)))
		else $error("line buffers not swapped at row end");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("operand stage filled without an accepted word");

endmodule

### rtl/flp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module flp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 66
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/flp_cell.sv
// One window cell: a word register that takes its left or its right neighbor on advance.
module flp_cell import flp_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic              sel,
	input  logic [DATA_W-1:0] d_a,
	input  logic [DATA_W-1:0] d_b,
	output logic [DATA_W-1:0] q
);

	always_ff @(posedge clk) begin
		if (en) begin
			q <= sel ? d_b : d_a;
		end
	end

endmodule

### rtl/flp_arith.sv
// Stencil sum, split scaling multiply and saturation pipeline with output register.
module flp_arith import flp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  operand_t          opnd,
	input  meta_t             meta,
	input  logic [DATA_W-1:0] inv,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] lap,
	output meta_t             out_meta
);

	logic ld2, ld3, ld4;
	logic v_s2, v_s3, v_s4;

	logic signed [SUM_W-1:0]  c_x, n_x, s_x, e_x, w_x, neg_c, sum_d;
	logic signed [SUM_W-1:0]  sum_s2;
	meta_t                    meta_s2, meta_s3, meta_s4;
	logic signed [FRAC_W:0]   inv_lo, inv_hi;
	logic signed [PROD_W-1:0] plo_d, phi_d, plo_s3, phi_s3;
	logic signed [Q_W-1:0]    q_d;
	logic                     ovf;
	logic [DATA_W-1:0]        lap_d, lap_s4;

	assign ld4      = !v_s4 || out_ready;
	assign ld3      = !v_s3 || ld4;
	assign ld2      = !v_s2 || ld3;
	assign in_ready = ld2;

	assign c_x   = SUM_W'(opnd.centre);
	assign neg_c = -c_x;
	assign n_x   = opnd.mirror.north ? neg_c : SUM_W'(opnd.north);
	assign s_x   = opnd.mirror.south ? neg_c : SUM_W'(opnd.south);
	assign e_x   = opnd.mirror.east  ? neg_c : SUM_W'(opnd.east);
	assign w_x   = opnd.mirror.west  ? neg_c : SUM_W'(opnd.west);
	assign sum_d = n_x + s_x + e_x + w_x - (c_x <<< CENTRE_SHIFT);

	assign inv_lo = $signed({1'b0, inv[FRAC_W-1:0]});
	assign inv_hi = $signed({1'b0, inv[DATA_W-1:FRAC_W]});
	assign plo_d  = sum_s2 * inv_lo;
	assign phi_d  = sum_s2 * inv_hi;

	assign q_d   = Q_W'(phi_s3) + Q_W'(plo_s3 >>> FRAC_W);
	assign ovf   = (q_d[Q_W-1:DATA_W-1] != {(Q_W-DATA_W+1){1'b0}})
		&& (q_d[Q_W-1:DATA_W-1] != {(Q_W-DATA_W+1){1'b1}});
	assign lap_d = ovf ? (q_d[Q_W-1] ? LAP_MIN : LAP_MAX) : q_d[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld2) v_s2 <= in_valid;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			sum_s2  <= sum_d;
			meta_s2 <= meta;
		end
		if (ld3) begin
			plo_s3  <= plo_d;
			phi_s3  <= phi_d;
			meta_s3 <= meta_s2;
		end
		if (ld4) begin
			lap_s4  <= lap_d;
			meta_s4 <= meta_s3;
		end
	end

	assign out_valid = v_s4;
	assign lap       = lap_s4;
	assign out_meta  = meta_s4;

endmodule
